[rtl/frm_pkg.sv]
// shared constants and types for the frame rate meter and limiter
package frm_pkg;

    // window of frame times kept for the average
    localparam int WINDOW      = 10;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W      = $clog2(WINDOW + 1);

    // field widths
    localparam int TIME_W      = 32;
    localparam int PERIOD_W    = 18;
    localparam int RATE_W      = 22;
    localparam int DELAY_W     = 10;

    // running sum of up to WINDOW frame times
    localparam int SUM_W       = TIME_W + FILL_W;

    // 1000 ms per second in Q8, and the rate numerator width
    localparam int MS_PER_S_Q8 = 256000;
    localparam int NUM_W       = $clog2(MS_PER_S_Q8 * WINDOW + 1);
    localparam int EXT_W       = (NUM_W > RATE_W) ? NUM_W : RATE_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4267);
    localparam logic [RATE_W-1:0]   RATE_MAX     = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0]   DEFAULT_RATE = RATE_W'(15360);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/frm_ring_ram.sv]
// simple dual port ram holding the ring of frame times
module frm_ring_ram #(
    parameter int DEPTH  = 10,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/frm_divider.sv]
// restoring divider, one quotient bit per cycle
module frm_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frm_pkg::t_div_req i_req,
    output frm_pkg::t_div_rsp o_rsp
);

    localparam int NUM_W = frm_pkg::NUM_W;
    localparam int SUM_W = frm_pkg::SUM_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_den;

    logic [SUM_W:0]   n_trial;
    logic [SUM_W:0]   n_diff;
    logic             n_ge;

    // trial subtraction of the divisor
    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[SUM_W-1:0] : n_trial[SUM_W-1:0];
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[rtl/frame_rate_meter_and_limiter.sv]
// top level of the frame rate meter and limiter
//
// One request per finished frame carries its start and end millisecond ticks.
// Each request returns one result: the averaged rate in fps (unsigned Q8),
// the frame time (end minus previous end) and the whole milliseconds still
// to wait to meet the configured frame period.
// Input and output both use valid/ready; the result sits in an output
// register, so the next request is taken while a result waits.
// One request is in work at a time. On acceptance the ring memory reads the
// oldest sample; the new sample is then written back as the restoring divider
// starts to form 256000 * count / sum, one quotient bit a cycle.
// A stalled receiver holds the result; a finished request then waits in
// the sequencer until the output register frees.
// Reset (synchronous, active low) empties the window, clears the sum and
// loads the period register with 4267 (about 60 fps). The ring memory is
// not cleared; the fill count guards reads of unwritten slots.
// The period register is written by i_cfg_wr_en and i_cfg_wr_data.
module frame_rate_meter_and_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [frm_pkg::PERIOD_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [frm_pkg::TIME_W-1:0]    i_frame_start_ms,
    input  logic [frm_pkg::TIME_W-1:0]    i_frame_end_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [frm_pkg::RATE_W-1:0]    o_rate_q8,
    output logic [frm_pkg::TIME_W-1:0]    o_frame_time_ms,
    output logic [frm_pkg::DELAY_W-1:0]   o_delay_ms
);

    localparam int SLOT_W   = frm_pkg::SLOT_W;
    localparam int FILL_W   = frm_pkg::FILL_W;
    localparam int SUM_W    = frm_pkg::SUM_W;
    localparam int TIME_W   = frm_pkg::TIME_W;
    localparam int PERIOD_W = frm_pkg::PERIOD_W;
    localparam int RATE_W   = frm_pkg::RATE_W;
    localparam int DELAY_W  = frm_pkg::DELAY_W;
    localparam int NUM_W    = frm_pkg::NUM_W;
    localparam int EXT_W    = frm_pkg::EXT_W;

    localparam logic [NUM_W-1:0] MS_Q8 = NUM_W'(frm_pkg::MS_PER_S_Q8);

    frm_pkg::t_state   r_state, n_state;
    frm_pkg::t_div_req div_req;
    frm_pkg::t_div_rsp div_rsp;

    logic [PERIOD_W-1:0] r_period;
    logic [SLOT_W-1:0]   r_slot;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [TIME_W-1:0]   r_prev_end;
    logic                r_seen_first;
    logic [TIME_W-1:0]   r_ftime;
    logic [DELAY_W-1:0]  r_delay;

    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_rate;
    logic [TIME_W-1:0]   r_out_ftime;
    logic [DELAY_W-1:0]  r_out_delay;

    logic                in_acc;
    logic                out_free;
    logic                load_out;
    logic                win_full;
    logic [TIME_W-1:0]   old_sample;
    logic [TIME_W-1:0]   n_ftime;
    logic [TIME_W-1:0]   n_elapsed;
    logic [DELAY_W-1:0]  n_delay;
    logic [SUM_W-1:0]    n_sum;
    logic [FILL_W-1:0]   n_fill;
    logic [SLOT_W-1:0]   n_slot;
    logic [EXT_W-1:0]    quot_ext;
    logic [RATE_W-1:0]   n_rate;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign win_full = (r_fill == FILL_W'(frm_pkg::WINDOW));

    // ring of frame times
    frm_ring_ram #(
        .DEPTH  (frm_pkg::WINDOW),
        .WIDTH  (TIME_W),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == frm_pkg::ST_READ),
        .i_wr_addr (r_slot),
        .i_wr_data (r_ftime),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_slot),
        .o_rd_data (old_sample)
    );

    // frame time and delay at the request
    always_comb begin
        n_ftime   = r_seen_first ? (i_frame_end_ms - r_prev_end) : '0;
        n_elapsed = i_frame_end_ms - i_frame_start_ms;
        if ((n_elapsed[TIME_W-1:DELAY_W] == '0) &&
            ({n_elapsed[DELAY_W-1:0], 8'b0} < r_period)) begin
            n_delay = r_period[PERIOD_W-1:8] - n_elapsed[DELAY_W-1:0];
        end else begin
            n_delay = '0;
        end
    end

    // window update once the old sample is read
    always_comb begin
        n_sum  = r_sum - (win_full ? SUM_W'(old_sample) : '0) + SUM_W'(r_ftime);
        n_fill = win_full ? r_fill : r_fill + FILL_W'(1);
        n_slot = (r_slot == SLOT_W'(frm_pkg::WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // divider request
    always_comb begin
        div_req.start = (r_state == frm_pkg::ST_READ);
        div_req.num   = MS_Q8 * NUM_W'(n_fill);
        div_req.den   = n_sum;
    end

    frm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // rate with zero sum default and saturation
    always_comb begin
        quot_ext = EXT_W'(div_rsp.quot);
        if (r_sum == '0) begin
            n_rate = frm_pkg::DEFAULT_RATE;
        end else if (quot_ext > EXT_W'(frm_pkg::RATE_MAX)) begin
            n_rate = frm_pkg::RATE_MAX;
        end else begin
            n_rate = quot_ext[RATE_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            frm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = frm_pkg::ST_READ;
                end
            end
            frm_pkg::ST_READ: begin
                n_state = frm_pkg::ST_DIVIDE;
            end
            frm_pkg::ST_DIVIDE: begin
                if (div_rsp.done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = frm_pkg::ST_IDLE;
                    end else begin
                        n_state = frm_pkg::ST_DONE;
                    end
                end
            end
            frm_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = frm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frm_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= frm_pkg::ST_IDLE;
            r_period     <= frm_pkg::PERIOD_RESET;
            r_slot       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_prev_end   <= '0;
            r_seen_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_prev_end   <= i_frame_end_ms;
                r_seen_first <= 1'b1;
            end
            if (r_state == frm_pkg::ST_READ) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_slot <= n_slot;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ftime <= n_ftime;
            r_delay <= n_delay;
        end
        if (load_out) begin
            r_out_rate  <= n_rate;
            r_out_ftime <= r_ftime;
            r_out_delay <= r_delay;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rate_q8       = r_out_rate;
    assign o_frame_time_ms = r_out_ftime;
    assign o_delay_ms      = r_out_delay;

endmodule

[rtl/frm_checker.sv]
// port level checks for the frame rate meter and limiter
module frm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [frm_pkg::RATE_W-1:0]   o_rate_q8,
    input logic [frm_pkg::TIME_W-1:0]   o_frame_time_ms,
    input logic [frm_pkg::DELAY_W-1:0]  o_delay_ms
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rate_q8) &&
        $stable(o_frame_time_ms) && $stable(o_delay_ms))
        else $error("result changed while stalled");

    // one request in work at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // no result right after a request
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // a new result only comes out of a busy phase
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while idle");

endmodule

bind frame_rate_meter_and_limiter frm_checker u_frm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_rate_q8       (o_rate_q8),
    .o_frame_time_ms (o_frame_time_ms),
    .o_delay_ms      (o_delay_ms)
);

[tb/sv/tb_frame_rate_meter_and_limiter.sv]
// testbench for the frame rate meter and limiter: directed and random frame events checked
module tb_frame_rate_meter_and_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = frm_pkg::WINDOW;
    localparam int TIME_W      = frm_pkg::TIME_W;
    localparam int PERIOD_W    = frm_pkg::PERIOD_W;
    localparam int RATE_W      = frm_pkg::RATE_W;
    localparam int DELAY_W     = frm_pkg::DELAY_W;
    localparam int MS_PER_S_Q8 = frm_pkg::MS_PER_S_Q8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = frm_pkg::PERIOD_RESET;
    localparam logic [RATE_W-1:0]   RATE_MAX     = frm_pkg::RATE_MAX;
    localparam logic [RATE_W-1:0]   DEFAULT_RATE = frm_pkg::DEFAULT_RATE;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    // one expected result
    typedef struct packed {
        logic [RATE_W-1:0]  rate_q8;
        logic [TIME_W-1:0]  frame_time_ms;
        logic [DELAY_W-1:0] delay_ms;
    } t_frame_result;

    // block ports
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_wr_en      = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wr_data    = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [TIME_W-1:0]   i_frame_start_ms = '0;
    logic [TIME_W-1:0]   i_frame_end_ms   = '0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    logic [RATE_W-1:0]   o_rate_q8;
    logic [TIME_W-1:0]   o_frame_time_ms;
    logic [DELAY_W-1:0]  o_delay_ms;

    // predictor state: window of frame times and the period register
    logic [TIME_W-1:0]   win_times [WINDOW] = '{default: '0};
    int unsigned         win_slot       = 0;
    int unsigned         win_fill       = 0;
    longint unsigned     win_sum        = 0;
    logic [TIME_W-1:0]   last_end_ms    = '0;
    logic                have_last_end  = 1'b0;
    logic [PERIOD_W-1:0] target_period  = PERIOD_RESET;

    t_frame_result       pending_results [$];
    logic [TIME_W-1:0]   tick_ms        = '0;
    int                  send_idle_pct  = 0;
    int                  stall_pct      = 0;
    int                  hold_request   = 0;
    int                  hold_left      = 0;
    int                  frames_sent    = 0;
    int                  results_checked = 0;
    int                  periods_used   = 0;
    int                  mismatches     = 0;

    frame_rate_meter_and_limiter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_start_ms (i_frame_start_ms),
        .i_frame_end_ms   (i_frame_end_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rate_q8        (o_rate_q8),
        .o_frame_time_ms  (o_frame_time_ms),
        .o_delay_ms       (o_delay_ms)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // expected rate, frame time and delay for one frame event
    function automatic t_frame_result predict_frame(logic [TIME_W-1:0] start_ms,
                                                    logic [TIME_W-1:0] end_ms);
        t_frame_result     res;
        logic [TIME_W-1:0] ftime;
        logic [TIME_W-1:0] elapsed;
        longint unsigned   rate;
        ftime = have_last_end ? end_ms - last_end_ms : '0;
        have_last_end = 1'b1;
        last_end_ms = end_ms;
        // full window: the oldest frame time leaves the sum
        if (win_fill >= WINDOW) begin
            win_sum -= win_times[win_slot];
        end else begin
            win_fill++;
        end
        win_times[win_slot] = ftime;
        win_sum += ftime;
        win_slot = (win_slot + 1) % WINDOW;
        // averaged rate, 60 fps when the window holds only zero times
        if (win_sum == 0) begin
            rate = DEFAULT_RATE;
        end else begin
            rate = (64'(MS_PER_S_Q8) * win_fill) / win_sum;
            if (rate > RATE_MAX) rate = RATE_MAX;
        end
        // whole ms left to the target period
        elapsed = end_ms - start_ms;
        res.rate_q8 = RATE_W'(rate);
        res.frame_time_ms = ftime;
        if (64'(target_period) > (64'(elapsed) << 8)) begin
            res.delay_ms = DELAY_W'(TIME_W'(target_period >> 8) - elapsed);
        end else begin
            res.delay_ms = '0;
        end
        return res;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // offer one frame event, sometimes with a random idle gap first
    task automatic send_frame(input logic [TIME_W-1:0] start_ms, input logic [TIME_W-1:0] end_ms);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_frame_start_ms <= start_ms;
        i_frame_end_ms   <= end_ms;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_frame(start_ms, end_ms));
        frames_sent++;
    endtask

    // frame streams: mostly steady ticks, with repeats, jumps, reversed and noise events
    task automatic send_frames(input int count);
        int unsigned       kind;
        logic [TIME_W-1:0] step_ms;
        logic [TIME_W-1:0] elapsed_ms;
        logic [TIME_W-1:0] start_ms;
        repeat (count) begin
            kind = $urandom_range(99);
            step_ms = $urandom_range(1, 50);
            if ($urandom_range(1) == 1) begin
                elapsed_ms = $urandom_range(0, (target_period >> 8) + 2);
            end else begin
                elapsed_ms = $urandom_range(0, step_ms);
            end
            if (kind < 8) begin
                step_ms = '0;
            end else if (kind < 15) begin
                step_ms = $urandom;
            end
            tick_ms += step_ms;
            start_ms = tick_ms - elapsed_ms;
            if (kind >= 15 && kind < 22) begin
                start_ms = tick_ms + $urandom_range(1, 1000);
            end else if (kind >= 22 && kind < 30) begin
                start_ms = $urandom;
                tick_ms = $urandom;
            end
            send_frame(start_ms, tick_ms);
        end
    endtask

    // let every expected result arrive, then settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        target_period = value;
        periods_used++;
    endtask

    // first event, zero-sum window, wraps and the delay boundary at the reset period
    task automatic test_edge_cases();
        send_frame('0, '0);
        send_frame('0, '0);
        // start after end
        send_frame(32'd5, '0);
        // largest frame time, then the end tick wraps to zero
        send_frame(32'hFFFF_FFF0, '1);
        send_frame('0, '0);
        // elapsed just under, at and over the 16 ms whole part
        send_frame(32'd185, 32'd200);
        send_frame(32'd284, 32'd300);
        send_frame(32'd383, 32'd400);
        // a full window of zero frame times
        repeat (WINDOW) send_frame(32'd400, 32'd400);
        // sum of one over a full window gives the top rate
        send_frame(32'd400, 32'd401);
        send_frame('0, '1);
        drain_results();
    endtask

    // zero, smallest, largest in range, all ones, and back to the reset period
    task automatic test_period_settings();
        logic [PERIOD_W-1:0] settings [5];
        settings = '{'0, PERIOD_W'(256), PERIOD_W'(256000), '1, PERIOD_RESET};
        foreach (settings[k]) begin
            write_period(settings[k]);
            send_frames(8);
            drain_results();
        end
    endtask

    // random frames under each idle and stall mix
    task automatic test_random_traffic();
        int send_pcts [4];
        int stall_pcts [4];
        send_pcts  = '{0, 45, 0, 17};
        stall_pcts = '{0, 0, 45, 17};
        foreach (send_pcts[k]) begin
            send_idle_pct = send_pcts[k];
            stall_pct     = stall_pcts[k];
            write_period($urandom_range(256, 256000));
            tick_ms = $urandom;
            send_frames(250);
            drain_results();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_period(PERIOD_RESET);
        hold_request <= HOLD_CYCLES;
        send_frames(40);
        drain_results();
    endtask

    // receiver: long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request <= 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual rate %0d time %0d delay %0d",
                         $time, o_rate_q8, o_frame_time_ms, o_delay_ms);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("rate_q8", want.rate_q8, o_rate_q8);
                check_field("frame_time_ms", want.frame_time_ms, o_frame_time_ms);
                check_field("delay_ms", want.delay_ms, o_delay_ms);
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_cases();
        test_period_settings();
        test_random_traffic();
        test_output_backpressure();
        $display("ran %0d frame events, %0d results checked, %0d period writes",
                 frames_sent, results_checked, periods_used);
        $display("idle/stall mixes and a %0d-cycle output hold-off, %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[frame_rate_meter_and_limiter.f]
rtl/frm_pkg.sv
rtl/frm_ring_ram.sv
rtl/frm_divider.sv
rtl/frame_rate_meter_and_limiter.sv
rtl/frm_checker.sv
tb/sv/tb_frame_rate_meter_and_limiter.sv
